// ===== hw/rtl/sapq_pkg.sv =====
package sapq_pkg;

  localparam int KEY_W   = 32;
  localparam int TAG_W   = 16;
  localparam int COUNT_W = 5;

  localparam logic CMD_PUSH = 1'b0;
  localparam logic CMD_POP  = 1'b1;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_CMP,
    S_PUT,
    S_POP,
    S_POP_DATA,
    S_DONE
  } state_t;

  typedef struct packed {
    logic signed [KEY_W-1:0] popped_key;
    logic [TAG_W-1:0]        popped_tag;
    logic                    pop_valid;
    logic [1:0]              status;
    logic [COUNT_W-1:0]      entry_count;
    logic                    is_empty;
  } result_t;

endpackage

// ===== hw/rtl/sapq_if.sv =====
interface sapq_in_if;
  logic                             valid;
  logic                             ready;
  logic                             command;
  logic signed [sapq_pkg::KEY_W-1:0] key;
  logic [sapq_pkg::TAG_W-1:0]       tag;

  modport source (output valid, command, key, tag, input ready);
  modport sink   (input valid, command, key, tag, output ready);
endinterface

interface sapq_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [sapq_pkg::KEY_W-1:0]  popped_key;
  logic [sapq_pkg::TAG_W-1:0]         popped_tag;
  logic                               pop_valid;
  logic [1:0]                         status;
  logic [sapq_pkg::COUNT_W-1:0]       entry_count;
  logic                               is_empty;

  modport source (output valid, popped_key, popped_tag, pop_valid, status, entry_count,
                  is_empty, input ready);
  modport sink   (input valid, popped_key, popped_tag, pop_valid, status, entry_count,
                  is_empty, output ready);
endinterface

// ===== hw/rtl/sapq_ram.sv =====
module sapq_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 16,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/sapq_ctrl.sv =====
module sapq_ctrl #(
  parameter int CAPACITY = 16,
  parameter int TAG_BITS = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic                               in_command,
  input  logic signed [sapq_pkg::KEY_W-1:0]  in_key,
  input  logic [sapq_pkg::TAG_W-1:0]         in_tag,
  output logic                               ram_we,
  output logic [$clog2(CAPACITY)-1:0]        ram_waddr,
  output logic [sapq_pkg::KEY_W+TAG_BITS-1:0] ram_wdata,
  output logic [$clog2(CAPACITY)-1:0]        ram_raddr,
  input  logic [sapq_pkg::KEY_W+TAG_BITS-1:0] ram_rdata,
  output logic                               res_valid,
  input  logic                               res_ready,
  output sapq_pkg::result_t                  res
);

  localparam int IW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  sapq_pkg::state_t state_r, state_nxt;
  logic [CW-1:0]                  count_r, count_nxt;
  logic [IW-1:0]                  idx_r, idx_nxt;
  logic signed [sapq_pkg::KEY_W-1:0] key_r, key_nxt;
  logic [TAG_BITS-1:0]            tag_r, tag_nxt;
  sapq_pkg::result_t              res_r, res_nxt;

  logic [CW-1:0]                  cnt_m1;
  logic [63:0]                    in_tag_w;
  logic [63:0]                    rd_tag_w;
  logic signed [sapq_pkg::KEY_W-1:0] rd_key;
  logic [TAG_BITS-1:0]            rd_tag;
  logic                           key_gt;

  function automatic logic [sapq_pkg::COUNT_W-1:0] cnt_port(input logic [CW-1:0] c);
    logic [31:0] w;
    w = 32'(c);
    return w[sapq_pkg::COUNT_W-1:0];
  endfunction

  assign cnt_m1   = count_r - CW'(1);
  assign in_tag_w = 64'(in_tag);
  assign rd_key   = ram_rdata[sapq_pkg::KEY_W+TAG_BITS-1:TAG_BITS];
  assign rd_tag   = ram_rdata[TAG_BITS-1:0];
  assign rd_tag_w = 64'(rd_tag);
  // the one shared compare: does the new key sit above the held entry
  assign key_gt   = key_r > rd_key;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sapq_pkg::S_IDLE;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
    key_r <= key_nxt;
    tag_r <= tag_nxt;
    res_r <= res_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    idx_nxt   = idx_r;
    key_nxt   = key_r;
    tag_nxt   = tag_r;
    res_nxt   = res_r;
    in_ready  = 1'b0;
    res_valid = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = idx_r + IW'(1);
    ram_wdata = {key_r, tag_r};
    ram_raddr = idx_r;

    case (state_r)
      sapq_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          key_nxt = in_key;
          tag_nxt = in_tag_w[TAG_BITS-1:0];
          idx_nxt = cnt_m1[IW-1:0];
          res_nxt = '0;
          res_nxt.entry_count = cnt_port(count_r);
          res_nxt.is_empty    = (count_r == '0);
          if (in_command == sapq_pkg::CMD_PUSH) begin
            if (count_r == CW'(CAPACITY)) begin
              res_nxt.status = sapq_pkg::ST_FULL;
              state_nxt      = sapq_pkg::S_DONE;
            end else if (count_r == '0) begin
              ram_we    = 1'b1;
              ram_waddr = '0;
              ram_wdata = {in_key, in_tag_w[TAG_BITS-1:0]};
              count_nxt = CW'(1);
              res_nxt.entry_count = cnt_port(CW'(1));
              res_nxt.is_empty    = 1'b0;
              state_nxt = sapq_pkg::S_DONE;
            end else begin
              state_nxt = sapq_pkg::S_READ;
            end
          end else begin
            if (count_r == '0) begin
              res_nxt.status = sapq_pkg::ST_EMPTY;
              state_nxt      = sapq_pkg::S_DONE;
            end else begin
              state_nxt = sapq_pkg::S_POP;
            end
          end
        end
      end

      sapq_pkg::S_READ: begin
        state_nxt = sapq_pkg::S_CMP;
      end

      sapq_pkg::S_CMP: begin
        ram_we = 1'b1;
        if (key_gt) begin
          // move the held entry up one place
          ram_wdata = ram_rdata;
          if (idx_r == '0) begin
            state_nxt = sapq_pkg::S_PUT;
          end else begin
            idx_nxt   = idx_r - IW'(1);
            state_nxt = sapq_pkg::S_READ;
          end
        end else begin
          count_nxt = count_r + CW'(1);
          res_nxt.entry_count = cnt_port(count_r + CW'(1));
          res_nxt.is_empty    = 1'b0;
          state_nxt = sapq_pkg::S_DONE;
        end
      end

      sapq_pkg::S_PUT: begin
        ram_we    = 1'b1;
        ram_waddr = '0;
        count_nxt = count_r + CW'(1);
        res_nxt.entry_count = cnt_port(count_r + CW'(1));
        res_nxt.is_empty    = 1'b0;
        state_nxt = sapq_pkg::S_DONE;
      end

      sapq_pkg::S_POP: begin
        state_nxt = sapq_pkg::S_POP_DATA;
      end

      sapq_pkg::S_POP_DATA: begin
        count_nxt              = cnt_m1;
        res_nxt.popped_key     = rd_key;
        res_nxt.popped_tag     = rd_tag_w[sapq_pkg::TAG_W-1:0];
        res_nxt.pop_valid      = 1'b1;
        res_nxt.entry_count    = cnt_port(cnt_m1);
        res_nxt.is_empty       = (cnt_m1 == '0);
        state_nxt              = sapq_pkg::S_DONE;
      end

      sapq_pkg::S_DONE: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_nxt = sapq_pkg::S_IDLE;
        end
      end

      default: begin
        state_nxt = sapq_pkg::S_IDLE;
      end
    endcase
  end

  assign res = res_r;

endmodule

// ===== hw/rtl/sorted_array_priority_queue_top.sv =====
// Sorted-array min priority queue, one item at a time through a read/compare/write sequencer.
// A push reads then compares the held entries from the top down, moving each smaller one up
// one place, with a final write state when the new entry lands at the bottom; a pop reads the
// top entry. Rejected pushes, pops on empty and pushes into an empty queue go straight to the
// result. The next word is taken once the result has entered the output register. The single
// registered RAM read port puts a read state before each compare. Reset empties the queue.
module sorted_array_priority_queue_top #(
  parameter int CAPACITY = 16,
  parameter int TAG_BITS = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  sapq_in_if.sink           in_ch,
  sapq_out_if.source        out_ch
);

  localparam int IW = $clog2(CAPACITY);
  localparam int EW = sapq_pkg::KEY_W + TAG_BITS;

  logic              ram_we;
  logic [IW-1:0]     ram_waddr;
  logic [EW-1:0]     ram_wdata;
  logic [IW-1:0]     ram_raddr;
  logic [EW-1:0]     ram_rdata;
  logic              res_valid;
  logic              res_ready;
  sapq_pkg::result_t res;

  logic              out_valid_r;
  sapq_pkg::result_t out_word_r;

  sapq_ram #(
    .WIDTH (EW),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  sapq_ctrl #(
    .CAPACITY (CAPACITY),
    .TAG_BITS (TAG_BITS)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_ready   (in_ch.ready),
    .in_command (in_ch.command),
    .in_key     (in_ch.key),
    .in_tag     (in_ch.tag),
    .ram_we     (ram_we),
    .ram_waddr  (ram_waddr),
    .ram_wdata  (ram_wdata),
    .ram_raddr  (ram_raddr),
    .ram_rdata  (ram_rdata),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res        (res)
  );

  // load a new word when the register is empty or the held one is being taken
  assign res_ready = !out_valid_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_word_r <= res;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.popped_key  = out_word_r.popped_key;
  assign out_ch.popped_tag  = out_word_r.popped_tag;
  assign out_ch.pop_valid   = out_word_r.pop_valid;
  assign out_ch.status      = out_word_r.status;
  assign out_ch.entry_count = out_word_r.entry_count;
  assign out_ch.is_empty    = out_word_r.is_empty;

endmodule

// ===== sim/sorted_array_priority_queue_top_tb.sv =====
`timescale 1ns / 1ps

class pq_scoreboard;
  localparam int DEPTH = 16;
  localparam int TAG_KEEP = 16;

  logic signed [sapq_pkg::KEY_W-1:0] held_key [DEPTH];
  logic [sapq_pkg::TAG_W-1:0]        held_tag [DEPTH];
  int                                held_count;
  sapq_pkg::result_t                 awaited_results [$];
  int                                errors;
  int                                n_push_ok;
  int                                n_push_full;
  int                                n_pop_ok;
  int                                n_pop_empty;

  function new();
    held_count  = 0;
    errors      = 0;
    n_push_ok   = 0;
    n_push_full = 0;
    n_pop_ok    = 0;
    n_pop_empty = 0;
  endfunction

  // Work out the result of one word and advance the held queue.
  function sapq_pkg::result_t predict_word(logic cmd, logic signed [sapq_pkg::KEY_W-1:0] key,
                                           logic [sapq_pkg::TAG_W-1:0] tag);
    sapq_pkg::result_t      r;
    int                     slot;
    logic [63:0]            keep_mask;
    r         = '0;
    keep_mask = (64'h1 << TAG_KEEP) - 64'h1;
    if (TAG_KEEP >= 64) keep_mask = '1;
    if (cmd == sapq_pkg::CMD_PUSH) begin
      if (held_count >= DEPTH) begin
        r.status = sapq_pkg::ST_FULL;
      end else begin
        // land after every held key greater than or equal to the new one
        slot = held_count;
        while (slot > 0 && key > held_key[slot-1]) slot--;
        for (int i = held_count; i > slot; i--) begin
          held_key[i] = held_key[i-1];
          held_tag[i] = held_tag[i-1];
        end
        held_key[slot] = key;
        held_tag[slot] = tag & keep_mask[sapq_pkg::TAG_W-1:0];
        held_count++;
        r.status = sapq_pkg::ST_OK;
      end
    end else begin
      if (held_count == 0) begin
        r.status = sapq_pkg::ST_EMPTY;
      end else begin
        held_count--;
        r.popped_key = held_key[held_count];
        r.popped_tag = held_tag[held_count];
        r.pop_valid  = 1'b1;
        r.status     = sapq_pkg::ST_OK;
      end
    end
    r.entry_count = held_count[sapq_pkg::COUNT_W-1:0];
    r.is_empty    = (held_count == 0);
    return r;
  endfunction

  function void note_word(logic cmd, logic signed [sapq_pkg::KEY_W-1:0] key,
                          logic [sapq_pkg::TAG_W-1:0] tag);
    awaited_results.push_back(predict_word(cmd, key, tag));
  endfunction

  function void compare_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endfunction

  function void check_word(sapq_pkg::result_t got);
    sapq_pkg::result_t want;
    if (awaited_results.size() == 0) begin
      errors++;
      $display("%0t ns: unexpected result word, expected none, actual %0h", $time, got);
      return;
    end
    want = awaited_results.pop_front();
    compare_field("popped_key", 32'(want.popped_key), 32'(got.popped_key));
    compare_field("popped_tag", 32'(want.popped_tag), 32'(got.popped_tag));
    compare_field("pop_valid", 32'(want.pop_valid), 32'(got.pop_valid));
    compare_field("status", 32'(want.status), 32'(got.status));
    compare_field("entry_count", 32'(want.entry_count), 32'(got.entry_count));
    compare_field("is_empty", 32'(want.is_empty), 32'(got.is_empty));
    if (want.status == sapq_pkg::ST_FULL) n_push_full++;
    else if (want.status == sapq_pkg::ST_EMPTY) n_pop_empty++;
    else if (want.pop_valid) n_pop_ok++;
    else n_push_ok++;
  endfunction
endclass

module sorted_array_priority_queue_top_tb;

  localparam int CAPACITY    = 16;
  localparam int TAG_BITS    = 16;
  localparam int RAND_WORDS  = 1200;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_WAIT  = 64;

  logic clk;
  logic rst_n;
  int   cycles = 0;
  int   burst_left;
  int   ready_mode = 0;
  int   ready_left = 0;
  int   ready_phase = 0;

  sapq_in_if  in_ch ();
  sapq_out_if out_ch ();

  pq_scoreboard sb;

  sorted_array_priority_queue_top #(
    .CAPACITY (CAPACITY),
    .TAG_BITS (TAG_BITS)
  ) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results outstanding", cycles,
               sb.awaited_results.size());
      $display("Some tests failed");
      $finish;
    end
  end

  // Receiver: switch between free flow, random stalls, one-in-four and long holds.
  always @(posedge clk) begin
    if (ready_left == 0) begin
      ready_mode <= $urandom_range(0, 3);
      ready_left <= $urandom_range(10, 80);
      ready_phase <= 0;
    end else begin
      ready_left <= ready_left - 1;
      ready_phase <= ready_phase + 1;
    end
    case (ready_mode)
      0: out_ch.ready <= 1'b1;
      1: out_ch.ready <= 1'($urandom_range(0, 1));
      2: out_ch.ready <= (ready_phase % 4 == 0);
      default: out_ch.ready <= (ready_phase % 16 > 11);
    endcase
  end

  always @(posedge clk) begin
    sapq_pkg::result_t got;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.popped_key  = out_ch.popped_key;
      got.popped_tag  = out_ch.popped_tag;
      got.pop_valid   = out_ch.pop_valid;
      got.status      = out_ch.status;
      got.entry_count = out_ch.entry_count;
      got.is_empty    = out_ch.is_empty;
      sb.check_word(got);
    end
  end

  task automatic send_word(logic cmd, logic signed [sapq_pkg::KEY_W-1:0] key,
                           logic [sapq_pkg::TAG_W-1:0] tag);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    in_ch.valid   <= 1'b1;
    in_ch.command <= cmd;
    in_ch.key     <= key;
    in_ch.tag     <= tag;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_word(cmd, key, tag);
    burst_left--;
  endtask

  function automatic logic signed [sapq_pkg::KEY_W-1:0] pick_key();
    case ($urandom_range(0, 9))
      0: return 32'sh7fff_ffff;
      1: return 32'sh8000_0000;
      2: return 32'sd0;
      3: return -32'sd1;
      4, 5, 6: return $signed($urandom_range(0, 8)) - 32'sd4;
      default: return $urandom;
    endcase
  endfunction

  initial begin
    int pop_pct;
    int phase_left;
    logic cmd;
    sb = new();
    burst_left  = 0;
    rst_n         <= 1'b0;
    in_ch.valid   <= 1'b0;
    in_ch.command <= sapq_pkg::CMD_PUSH;
    in_ch.key     <= '0;
    in_ch.tag     <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: pop on empty, key extremes, insert at the front, equal keys, fill past full.
    send_word(sapq_pkg::CMD_POP, 32'sh1234_5678, 16'hffff);
    send_word(sapq_pkg::CMD_PUSH, 32'sh8000_0000, 16'h0000);
    send_word(sapq_pkg::CMD_PUSH, 32'sh7fff_ffff, 16'hffff);
    send_word(sapq_pkg::CMD_PUSH, 32'sd0, 16'h00a5);
    send_word(sapq_pkg::CMD_PUSH, -32'sd1, 16'h5a00);
    send_word(sapq_pkg::CMD_PUSH, 32'sd5, 16'h0001);
    send_word(sapq_pkg::CMD_PUSH, 32'sd5, 16'h0002);
    send_word(sapq_pkg::CMD_PUSH, 32'sd5, 16'h0003);
    repeat (4) send_word(sapq_pkg::CMD_POP, 32'sd0, 16'h0000);
    for (int i = 0; i < CAPACITY - 3; i++) begin
      send_word(sapq_pkg::CMD_PUSH, $urandom, 16'($urandom_range(0, 16'hffff)));
    end
    send_word(sapq_pkg::CMD_PUSH, 32'sh7fff_ffff, 16'hbeef);

    // Random: long fill, drain and balanced stretches so full and empty both recur.
    phase_left = 0;
    pop_pct    = 50;
    for (int n = 0; n < RAND_WORDS; n++) begin
      if (phase_left == 0) begin
        case ($urandom_range(0, 2))
          0: pop_pct = 15;
          1: pop_pct = 85;
          default: pop_pct = 50;
        endcase
        phase_left = $urandom_range(20, 60);
      end
      phase_left--;
      cmd = ($urandom_range(0, 99) < pop_pct) ? sapq_pkg::CMD_POP : sapq_pkg::CMD_PUSH;
      send_word(cmd, pick_key(), 16'($urandom_range(0, 16'hffff)));
    end
    in_ch.valid <= 1'b0;

    while (sb.awaited_results.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("Covered %0d pushes stored, %0d dropped at full, %0d pops returned, %0d on empty",
             sb.n_push_ok, sb.n_push_full, sb.n_pop_ok, sb.n_pop_empty);
    if (sb.errors == 0 && sb.awaited_results.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule
